/* hw/rtl/record_update_sequence_fixup_core_assert.svh */
// Assertion macros for the update sequence fix-up core checker.
// Expects clk and arst_n in the scope of each use.
`ifndef RECORD_UPDATE_SEQUENCE_FIXUP_CORE_ASSERT_SVH
`define RECORD_UPDATE_SEQUENCE_FIXUP_CORE_ASSERT_SVH

// same-cycle implication
`define RUSF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rusf check failed");

// next-cycle implication
`define RUSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rusf check failed");

`endif

/* hw/rtl/rusf_pkg.sv */
// Shared types and constants of the update sequence fix-up core.
// No dependencies.
`default_nettype none
package rusf_pkg;
	localparam int WORD_W    = 16;
	localparam int REG_W     = 13;
	localparam int ADDR_W    = 11;
	localparam int BUF_WORDS = 2 ** ADDR_W;
	localparam int REC_MAX   = 2 * BUF_WORDS;
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 3;

	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_APPLY  = 2'd1;
	localparam logic [1:0] REQ_COMMIT = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	localparam logic REG_SECTOR = 1'b0;
	localparam logic REG_RECORD = 1'b1;

	localparam logic [ADDR_W-1:0] HDR_OFF_WORD = ADDR_W'(2);
	localparam logic [ADDR_W-1:0] HDR_CNT_WORD = ADDR_W'(3);

	typedef struct packed {
		logic [REG_W-1:0] sector_bytes;
		logic [REG_W-1:0] record_bytes;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] usa_off;
		logic [WORD_W-1:0] usa_cnt;
	} hdr_fields_t;
endpackage
`default_nettype wire

/* hw/rtl/rusf_ram.sv */
// Single-port record buffer with registered read data.
// Depends on rusf_pkg.
`default_nettype none
module rusf_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [rusf_pkg::ADDR_W-1:0] addr,
	input  wire logic [rusf_pkg::WORD_W-1:0] wdata,
	output logic      [rusf_pkg::WORD_W-1:0] rdata
);
	logic [rusf_pkg::WORD_W-1:0] mem [rusf_pkg::BUF_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

/* hw/rtl/rusf_hdr.sv */
// Header check: one registered multiply of sector size by sector count,
// plus range and alignment flags. Depends on rusf_pkg.
`default_nettype none
module rusf_hdr (
	input  wire logic                  clk,
	input  wire rusf_pkg::cfg_t        cfg,
	input  wire rusf_pkg::hdr_fields_t hdr,
	output logic                       ok
);
	localparam int PROD_W = rusf_pkg::REG_W + rusf_pkg::WORD_W;

	logic [rusf_pkg::WORD_W-1:0]  cnt_m1;
	logic [PROD_W-1:0]            prod_c;
	logic                         off_le;
	logic [rusf_pkg::REG_W-1:0]   room;
	logic                         fits;
	logic                         flags_c;
	logic [PROD_W-1:0]            prod_s1;
	logic                         flags_s1;

	always_comb begin
		cnt_m1 = hdr.usa_cnt - rusf_pkg::WORD_W'(1);
		prod_c = PROD_W'(cfg.sector_bytes) * PROD_W'(cnt_m1);
		off_le = hdr.usa_off <= rusf_pkg::WORD_W'(cfg.record_bytes);
		room   = cfg.record_bytes - hdr.usa_off[rusf_pkg::REG_W-1:0];
		fits   = {hdr.usa_cnt, 1'b0} <= (rusf_pkg::WORD_W + 1)'(room);
		flags_c = (cfg.sector_bytes != '0) && !cfg.sector_bytes[0]
			&& (cfg.record_bytes <= rusf_pkg::REG_W'(rusf_pkg::REC_MAX))
			&& (hdr.usa_cnt >= rusf_pkg::WORD_W'(2))
			&& off_le && fits && !hdr.usa_off[0];
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod_c;
		flags_s1 <= flags_c;
	end

	assign ok = flags_s1 && (prod_s1 == PROD_W'(cfg.record_bytes));
endmodule
`default_nettype wire

/* hw/rtl/record_update_sequence_fixup_core.sv */
// Top level of the update sequence fix-up core: APB registers, sequencer
// and output register. Depends on rusf_pkg, rusf_ram and rusf_hdr.
//
// A single-port 2048 x 16 record buffer serves word writes, word reads and
// the apply and commit fix-up walks, one memory access per cycle under a
// small sequencer. A write or read beat passes through states IDLE and FIN.
// Apply and commit first read words 2 and 3 and check the header in states
// H2, H3, MUL and CHK; a failing header goes straight to FIN. Apply then
// runs A0 to A3 per sector, and commit runs C0 and C1 once and then C2 to
// C5 per sector, for n = count - 1 sectors; an apply tail mismatch ends
// the walk at once. A new input beat is taken only while the sequencer is
// idle; a finished result waits in the output register.
`default_nettype none
module record_update_sequence_fixup_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rusf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rusf_pkg::DATA_W-1:0]  pwdata,
	output logic      [rusf_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   req_type,
	input  wire logic [rusf_pkg::ADDR_W-1:0]  word_index,
	input  wire logic [rusf_pkg::WORD_W-1:0]  write_word,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [rusf_pkg::WORD_W-1:0]  read_word,
	output logic                              status
);
	localparam int AW = rusf_pkg::ADDR_W;
	localparam int WW = rusf_pkg::WORD_W;
	localparam int TW = AW + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FIN  = 4'd1;
	localparam logic [3:0] S_H2   = 4'd2;
	localparam logic [3:0] S_H3   = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_A0   = 4'd6;
	localparam logic [3:0] S_A1   = 4'd7;
	localparam logic [3:0] S_A2   = 4'd8;
	localparam logic [3:0] S_A3   = 4'd9;
	localparam logic [3:0] S_C0   = 4'd10;
	localparam logic [3:0] S_C1   = 4'd11;
	localparam logic [3:0] S_C2   = 4'd12;
	localparam logic [3:0] S_C3   = 4'd13;
	localparam logic [3:0] S_C4   = 4'd14;
	localparam logic [3:0] S_C5   = 4'd15;

	rusf_pkg::cfg_t        cfg_q;
	rusf_pkg::hdr_fields_t hdr_q;
	logic [3:0]            state_q;
	logic [1:0]            req_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         usa_q;
	logic [TW-1:0]         tail_q;
	logic [TW-1:0]         half_q;
	logic [TW-1:0]         k_q;
	logic [WW-1:0]         cur_q;
	logic                  st_q;
	logic                  out_valid_q;
	logic [WW-1:0]         read_word_q;
	logic                  status_q;

	logic                  cfg_wr;
	logic                  in_acc;
	logic                  slot_free;
	logic                  hdr_ok;
	logic                  ram_we;
	logic [AW-1:0]         ram_addr;
	logic [WW-1:0]         ram_wdata;
	logic [WW-1:0]         ram_rdata;
	logic [TW-1:0]         usa_k;
	logic [TW-1:0]         tail_nx;
	logic [TW-1:0]         k_nx;
	logic                  last;
	logic [WW-1:0]         seq_inc;
	logic [WW-1:0]         seq;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign in_ready  = state_q == S_IDLE;
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign read_word = read_word_q;
	assign status    = status_q;

	always_comb begin
		case (paddr[2])
			rusf_pkg::REG_SECTOR: prdata = rusf_pkg::DATA_W'(cfg_q.sector_bytes);
			rusf_pkg::REG_RECORD: prdata = rusf_pkg::DATA_W'(cfg_q.record_bytes);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sector_bytes <= rusf_pkg::REG_W'(512);
			cfg_q.record_bytes <= rusf_pkg::REG_W'(1024);
		end else if (cfg_wr) begin
			case (paddr[2])
				rusf_pkg::REG_SECTOR: cfg_q.sector_bytes <= pwdata[rusf_pkg::REG_W-1:0];
				rusf_pkg::REG_RECORD: cfg_q.record_bytes <= pwdata[rusf_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	rusf_hdr u_hdr (
		.clk (clk),
		.cfg (cfg_q),
		.hdr (hdr_q),
		.ok  (hdr_ok)
	);

	rusf_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		usa_k   = TW'(usa_q) + k_q;
		tail_nx = tail_q + half_q;
		k_nx    = k_q + TW'(1);
		last    = WW'(k_q) == (hdr_q.usa_cnt - WW'(1));
		seq_inc = ram_rdata + WW'(1);
		seq     = (seq_inc == '0) ? WW'(1) : seq_inc;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = ram_rdata;
		case (state_q)
			S_IDLE: begin
				ram_wdata = write_word;
				if (req_type == rusf_pkg::REQ_WRITE || req_type == rusf_pkg::REQ_READ) begin
					ram_addr = word_index;
					ram_we   = in_valid && (req_type == rusf_pkg::REQ_WRITE);
				end else begin
					ram_addr = rusf_pkg::HDR_OFF_WORD;
				end
			end
			S_H2: ram_addr = rusf_pkg::HDR_CNT_WORD;
			S_A0: ram_addr = tail_q[AW-1:0];
			S_A1: ram_addr = usa_q;
			S_A2: ram_addr = usa_k[AW-1:0];
			S_A3: begin
				ram_addr = tail_q[AW-1:0];
				ram_we   = 1'b1;
			end
			S_C0: ram_addr = usa_q;
			S_C1: begin
				ram_addr  = usa_q;
				ram_wdata = seq;
				ram_we    = 1'b1;
			end
			S_C2: ram_addr = tail_q[AW-1:0];
			S_C3: begin
				ram_addr = usa_k[AW-1:0];
				ram_we   = 1'b1;
			end
			S_C4: ram_addr = usa_q;
			S_C5: begin
				ram_addr = tail_q[AW-1:0];
				ram_we   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= req_type;
				idx_q <= word_index;
				st_q  <= 1'b0;
			end
			S_H2: hdr_q.usa_off <= ram_rdata;
			S_H3: hdr_q.usa_cnt <= ram_rdata;
			S_CHK: begin
				st_q   <= !hdr_ok;
				usa_q  <= hdr_q.usa_off[AW:1];
				half_q <= cfg_q.sector_bytes[TW:1];
				tail_q <= cfg_q.sector_bytes[TW:1] - TW'(1);
				k_q    <= TW'(1);
			end
			S_A1: cur_q <= ram_rdata;
			S_A2: st_q <= cur_q != ram_rdata;
			S_A3, S_C5: begin
				tail_q <= tail_nx;
				k_q    <= k_nx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (req_type == rusf_pkg::REQ_APPLY || req_type == rusf_pkg::REQ_COMMIT) begin
							state_q <= S_H2;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_H2:  state_q <= S_H3;
				S_H3:  state_q <= S_MUL;
				S_MUL: state_q <= S_CHK;
				S_CHK: begin
					if (!hdr_ok) begin
						state_q <= S_FIN;
					end else if (req_q == rusf_pkg::REQ_APPLY) begin
						state_q <= S_A0;
					end else begin
						state_q <= S_C0;
					end
				end
				S_A0: state_q <= S_A1;
				S_A1: state_q <= S_A2;
				S_A2: state_q <= (cur_q != ram_rdata) ? S_FIN : S_A3;
				S_A3: state_q <= last ? S_FIN : S_A0;
				S_C0: state_q <= S_C1;
				S_C1: state_q <= S_C2;
				S_C2: state_q <= S_C3;
				S_C3: state_q <= S_C4;
				S_C4: state_q <= S_C5;
				S_C5: state_q <= last ? S_FIN : S_C2;
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && slot_free) begin
			read_word_q <= (req_q == rusf_pkg::REQ_READ) ? ram_rdata : '0;
			status_q    <= st_q;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/rusf_checker.sv */
// Port-level checker for the update sequence fix-up core, bound to the top.
// Depends on rusf_pkg and record_update_sequence_fixup_core_assert.svh.
`default_nettype none
`include "record_update_sequence_fixup_core_assert.svh"
module rusf_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         psel,
	input wire logic                         penable,
	input wire logic                         pwrite,
	input wire logic [rusf_pkg::PADDR_W-1:0] paddr,
	input wire logic [rusf_pkg::DATA_W-1:0]  pwdata,
	input wire logic [rusf_pkg::DATA_W-1:0]  prdata,
	input wire logic                         pready,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic [1:0]                   req_type,
	input wire logic [rusf_pkg::ADDR_W-1:0]  word_index,
	input wire logic [rusf_pkg::WORD_W-1:0]  write_word,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [rusf_pkg::WORD_W-1:0]  read_word,
	input wire logic                         status
);
	logic cfg_wr;
	logic in_beat;

	assign cfg_wr  = psel && penable && pwrite && pready;
	assign in_beat = in_valid && in_ready;

	`RUSF_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready)
	`RUSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(read_word) && $stable(status))
	`RUSF_ASSERT_NOW(a_corrupt_no_data, out_valid && status, read_word == '0)
	`RUSF_ASSERT_NOW(a_cfg_readback,
		$past(cfg_wr) && (paddr[2] == $past(paddr[2])) && !$past(req_type[1] && 1'b0),
		prdata[rusf_pkg::REG_W-1:0] == $past(pwdata[rusf_pkg::REG_W-1:0]))
endmodule

bind record_update_sequence_fixup_core rusf_checker u_rusf_checker (.*);
`default_nettype wire
